>>> src/source_token_scanner_core_assert.svh
// Assertion macros for the source token scanner.
// Defining ASSERT_OFF turns every macro into an empty body.
`ifndef SOURCE_TOKEN_SCANNER_CORE_ASSERT_SVH
`define SOURCE_TOKEN_SCANNER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define STSC_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("stsc: assertion failed");
`define STSC_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("stsc: assertion failed");
`else
`define STSC_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`define STSC_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

>>> src/stsc_pkg.sv
// Shared types, codes and helper functions of the source token scanner.
// No dependencies; used by every module of the block.
`default_nettype none
package stsc_pkg;

	localparam int POS_W   = 16;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);
	localparam int Q_ROOM  = QDEPTH - 2;

	typedef logic [POS_W-1:0] pos_t;

	localparam logic [4:0] KIND_END       = 5'd0;
	localparam logic [4:0] KIND_NUMBER    = 5'd1;
	localparam logic [4:0] KIND_IDENT     = 5'd2;
	localparam logic [4:0] KIND_BEGIN     = 5'd3;
	localparam logic [4:0] KIND_END_KW    = 5'd4;
	localparam logic [4:0] KIND_ASSIGN    = 5'd5;
	localparam logic [4:0] KIND_EQUAL     = 5'd6;
	localparam logic [4:0] KIND_OP_BASE   = 5'd7;
	localparam logic [4:0] KIND_UNKNOWN   = 5'd17;
	localparam logic [4:0] KIND_DOUBLE_US = 5'd18;
	localparam logic [4:0] KIND_TRAIL_US  = 5'd19;

	localparam logic [7:0] CH_END   = 8'h24;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_US    = 8'h5F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;

	typedef enum logic [4:0] {
		MODE_IDLE = 5'b00001,
		MODE_NUM  = 5'b00010,
		MODE_ID   = 5'b00100,
		MODE_EQ   = 5'b01000,
		MODE_COMM = 5'b10000
	} mode_t;

	typedef enum logic [1:0] {
		KW_NONE  = 2'd0,
		KW_BEGIN = 2'd1,
		KW_END   = 2'd2
	} kw_t;

	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [7:0]  ubyte;
		logic        last;
	} token_t;

	typedef struct packed {
		logic   a_v;
		logic   b_v;
		token_t a;
		token_t b;
	} push_t;

	typedef struct packed {
		logic idle;
	} fstat_t;

	typedef struct packed {
		logic       hit;
		logic [4:0] kind;
	} op_t;

	function automatic logic is_digit(logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_letter(logic [7:0] b);
		return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
	endfunction

	function automatic logic is_blank(logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL);
	endfunction

	function automatic pos_t sat_inc(pos_t v);
		return (v == '1) ? v : v + POS_W'(1);
	endfunction

	function automatic logic [15:0] clip16(pos_t v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic op_t op_kind(logic [7:0] b);
		op_t r;
		r.hit = 1'b1;
		unique case (b)
			8'h28: r.kind = KIND_OP_BASE + 5'd0;
			8'h29: r.kind = KIND_OP_BASE + 5'd1;
			8'h7B: r.kind = KIND_OP_BASE + 5'd2;
			8'h7D: r.kind = KIND_OP_BASE + 5'd3;
			8'h2B: r.kind = KIND_OP_BASE + 5'd4;
			8'h2D: r.kind = KIND_OP_BASE + 5'd5;
			8'h2A: r.kind = KIND_OP_BASE + 5'd6;
			8'h2F: r.kind = KIND_OP_BASE + 5'd7;
			8'h3B: r.kind = KIND_OP_BASE + 5'd8;
			8'h2C: r.kind = KIND_OP_BASE + 5'd9;
			default: begin
				r.hit  = 1'b0;
				r.kind = KIND_UNKNOWN;
			end
		endcase
		return r;
	endfunction

	function automatic kw_t kw_next(kw_t kw, pos_t idx, logic [7:0] b);
		logic ok;
		ok = 1'b0;
		unique case (kw)
			KW_BEGIN: ok = (idx == POS_W'(0) && b == 8'h62) || (idx == POS_W'(1) && b == 8'h65)
				|| (idx == POS_W'(2) && b == 8'h67) || (idx == POS_W'(3) && b == 8'h69)
				|| (idx == POS_W'(4) && b == 8'h6E);
			KW_END: ok = (idx == POS_W'(0) && b == 8'h65) || (idx == POS_W'(1) && b == 8'h6E)
				|| (idx == POS_W'(2) && b == 8'h64);
			default: ok = 1'b0;
		endcase
		return ok ? kw : KW_NONE;
	endfunction

	function automatic token_t mk_token(logic [4:0] kind, pos_t start, pos_t len,
		logic [7:0] ub);
		token_t t;
		t.kind   = kind;
		t.start  = clip16(start);
		t.length = clip16(len);
		t.ubyte  = ub;
		t.last   = 1'b0;
		return t;
	endfunction

endpackage
`default_nettype wire

>>> src/source_token_scanner_core.sv
// Top level of the source token scanner: front end, token queue, back end.
// Depends on stsc_pkg, stsc_front, stsc_queue, stsc_back and the assert header.
//
// The scanner takes one source byte per cycle unless stalled and turns it into
// zero, one or two tokens (kind, start, length, unknown byte, last-of-run
// flag); '$' flushes any open token, emits an end token and restarts byte
// positions at zero. The front end state machine classifies a byte in the
// cycle it is accepted and writes its tokens into a four-entry queue; an output
// register drains the queue at one token per cycle when not stalled. Tokens
// pass through the queue and then the output register; a byte's second token
// follows its first. Input is held off while the queue holds more than two
// tokens, so the sustained rate is one byte per cycle as long as the token
// stream averages at most one token per byte and the output is not stalled;
// two-token bytes back-to-back are bound by the one-token-per-cycle output side.
`default_nettype none
`include "source_token_scanner_core_assert.svh"
module source_token_scanner_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  source_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [4:0]       token_kind,
	output logic [15:0]      token_start,
	output logic [15:0]      token_length,
	output logic [7:0]       unknown_byte,
	output logic             last_of_run
);

	stsc_pkg::push_t             push;
	stsc_pkg::fstat_t            fstat;
	stsc_pkg::token_t            head, tok;
	logic                        q_valid, pop, acc;
	logic [stsc_pkg::QCNT_W-1:0] q_count;

	assign in_stall = (q_count > stsc_pkg::QCNT_W'(stsc_pkg::Q_ROOM));
	assign acc      = in_valid && !in_stall;

	stsc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.source_byte (source_byte),
		.push        (push),
		.stat        (fstat)
	);

	stsc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.pop     (pop),
		.head    (head),
		.q_valid (q_valid),
		.count   (q_count)
	);

	stsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_valid   (q_valid),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.tok       (tok)
	);

	assign token_kind   = tok.kind;
	assign token_start  = tok.start;
	assign token_length = tok.length;
	assign unknown_byte = tok.ubyte;
	assign last_of_run  = tok.last;

	`STSC_ASSERT_IMPL(a_q_bound, clk, arst_n, 1'b1, q_count <= stsc_pkg::QCNT_W'(stsc_pkg::QDEPTH))
	`STSC_ASSERT_NEXT(a_end_idle, clk, arst_n, acc && source_byte == stsc_pkg::CH_END, fstat.idle)
	`STSC_ASSERT_IMPL(a_run_follow, clk, arst_n, out_valid && !last_of_run, q_count != '0)

endmodule
`default_nettype wire

>>> src/stsc_front.sv
// Front end: scan state machine, one byte per accepted item, up to two tokens.
// Depends on stsc_pkg.
`default_nettype none
module stsc_front (
	input  wire  logic              clk,
	input  wire  logic              arst_n,
	input  wire  logic              acc,
	input  wire  logic [7:0]        source_byte,
	output stsc_pkg::push_t         push,
	output stsc_pkg::fstat_t        stat
);

	stsc_pkg::mode_t mode_q, mode_d;
	stsc_pkg::pos_t  start_q, start_d;
	stsc_pkg::pos_t  len_q, len_d;
	stsc_pkg::kw_t   kw_q, kw_d;
	logic            pu_q, pu_d;
	stsc_pkg::pos_t  pos_q, pos_d;

	stsc_pkg::token_t tok_a, tok_b;
	logic             a_v, b_v, fresh;
	stsc_pkg::op_t    op;
	logic [4:0]       ident_kind;
	logic [7:0]       b;
	logic             b_dig, b_let, b_us;

	assign b     = source_byte;
	assign b_dig = stsc_pkg::is_digit(b);
	assign b_let = stsc_pkg::is_letter(b);
	assign b_us  = (b == stsc_pkg::CH_US);
	assign op    = stsc_pkg::op_kind(b);

	always_comb begin
		if (pu_q) begin
			ident_kind = stsc_pkg::KIND_TRAIL_US;
		end else if (kw_q == stsc_pkg::KW_BEGIN && len_q == stsc_pkg::POS_W'(5)) begin
			ident_kind = stsc_pkg::KIND_BEGIN;
		end else if (kw_q == stsc_pkg::KW_END && len_q == stsc_pkg::POS_W'(3)) begin
			ident_kind = stsc_pkg::KIND_END_KW;
		end else begin
			ident_kind = stsc_pkg::KIND_IDENT;
		end
	end

	always_comb begin
		mode_d  = mode_q;
		start_d = start_q;
		len_d   = len_q;
		kw_d    = kw_q;
		pu_d    = pu_q;
		pos_d   = stsc_pkg::sat_inc(pos_q);
		tok_a   = '0;
		tok_b   = '0;
		a_v     = 1'b0;
		b_v     = 1'b0;
		fresh   = 1'b0;
		if (b == stsc_pkg::CH_END) begin
			unique case (mode_q)
				stsc_pkg::MODE_NUM: begin
					a_v   = 1'b1;
					tok_a = stsc_pkg::mk_token(stsc_pkg::KIND_NUMBER, start_q, len_q, 8'h00);
				end
				stsc_pkg::MODE_ID: begin
					a_v   = 1'b1;
					tok_a = stsc_pkg::mk_token(ident_kind, start_q, len_q, 8'h00);
				end
				stsc_pkg::MODE_EQ: begin
					a_v   = 1'b1;
					tok_a = stsc_pkg::mk_token(stsc_pkg::KIND_ASSIGN, start_q,
						stsc_pkg::POS_W'(1), 8'h00);
				end
				default: a_v = 1'b0;
			endcase
			b_v     = 1'b1;
			tok_b   = stsc_pkg::mk_token(stsc_pkg::KIND_END, pos_q, '0, 8'h00);
			mode_d  = stsc_pkg::MODE_IDLE;
			start_d = '0;
			len_d   = '0;
			kw_d    = stsc_pkg::KW_NONE;
			pu_d    = 1'b0;
			pos_d   = '0;
		end else begin
			unique case (mode_q)
				stsc_pkg::MODE_NUM: begin
					if (b_dig) begin
						len_d = stsc_pkg::sat_inc(len_q);
					end else begin
						a_v   = 1'b1;
						tok_a = stsc_pkg::mk_token(stsc_pkg::KIND_NUMBER, start_q, len_q, 8'h00);
						fresh = 1'b1;
					end
				end
				stsc_pkg::MODE_ID: begin
					if (b_let || b_dig || b_us) begin
						if (b_us && pu_q) begin
							a_v   = 1'b1;
							tok_a = stsc_pkg::mk_token(stsc_pkg::KIND_DOUBLE_US, start_q, len_q,
								8'h00);
							fresh = 1'b1;
						end else begin
							kw_d  = stsc_pkg::kw_next(kw_q, len_q, b);
							len_d = stsc_pkg::sat_inc(len_q);
							pu_d  = b_us;
						end
					end else begin
						a_v   = 1'b1;
						tok_a = stsc_pkg::mk_token(ident_kind, start_q, len_q, 8'h00);
						fresh = 1'b1;
					end
				end
				stsc_pkg::MODE_EQ: begin
					a_v = 1'b1;
					if (b == stsc_pkg::CH_EQ) begin
						tok_a  = stsc_pkg::mk_token(stsc_pkg::KIND_EQUAL, start_q,
							stsc_pkg::POS_W'(2), 8'h00);
						mode_d = stsc_pkg::MODE_IDLE;
					end else begin
						tok_a = stsc_pkg::mk_token(stsc_pkg::KIND_ASSIGN, start_q,
							stsc_pkg::POS_W'(1), 8'h00);
						fresh = 1'b1;
					end
				end
				stsc_pkg::MODE_COMM: begin
					if (b == stsc_pkg::CH_NL) begin
						mode_d = stsc_pkg::MODE_IDLE;
					end
				end
				stsc_pkg::MODE_IDLE: fresh = 1'b1;
				default: fresh = 1'b1;
			endcase
			if (fresh) begin
				mode_d = stsc_pkg::MODE_IDLE;
				if (stsc_pkg::is_blank(b)) begin
					mode_d = stsc_pkg::MODE_IDLE;
				end else if (b == stsc_pkg::CH_TILDE) begin
					mode_d = stsc_pkg::MODE_COMM;
				end else if (b_dig || b_let || b == stsc_pkg::CH_EQ) begin
					start_d = pos_q;
					len_d   = stsc_pkg::POS_W'(1);
					if (b == stsc_pkg::CH_EQ) begin
						mode_d = stsc_pkg::MODE_EQ;
					end else if (b_dig) begin
						mode_d = stsc_pkg::MODE_NUM;
					end else begin
						mode_d = stsc_pkg::MODE_ID;
						pu_d   = 1'b0;
						if (b == 8'h62) begin
							kw_d = stsc_pkg::KW_BEGIN;
						end else if (b == 8'h65) begin
							kw_d = stsc_pkg::KW_END;
						end else begin
							kw_d = stsc_pkg::KW_NONE;
						end
					end
				end else begin
					b_v = 1'b1;
					if (op.hit) begin
						tok_b = stsc_pkg::mk_token(op.kind, pos_q, stsc_pkg::POS_W'(1), 8'h00);
					end else begin
						tok_b = stsc_pkg::mk_token(stsc_pkg::KIND_UNKNOWN, pos_q,
							stsc_pkg::POS_W'(1), b);
					end
				end
			end
		end
		if (b_v) begin
			tok_b.last = 1'b1;
		end else if (a_v) begin
			tok_a.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= stsc_pkg::MODE_IDLE;
			start_q <= '0;
			len_q   <= '0;
			kw_q    <= stsc_pkg::KW_NONE;
			pu_q    <= 1'b0;
			pos_q   <= '0;
		end else if (acc) begin
			mode_q  <= mode_d;
			start_q <= start_d;
			len_q   <= len_d;
			kw_q    <= kw_d;
			pu_q    <= pu_d;
			pos_q   <= pos_d;
		end
	end

	assign push.a_v  = acc && a_v;
	assign push.b_v  = acc && b_v;
	assign push.a    = tok_a;
	assign push.b    = tok_b;
	assign stat.idle = (mode_q == stsc_pkg::MODE_IDLE) && (pos_q == '0);

endmodule
`default_nettype wire

>>> src/stsc_queue.sv
// Token queue between front and back: two writes and one read per cycle.
// Depends on stsc_pkg.
`default_nettype none
module stsc_queue (
	input  wire  logic                        clk,
	input  wire  logic                        arst_n,
	input  wire  stsc_pkg::push_t             push,
	input  wire  logic                        pop,
	output stsc_pkg::token_t                  head,
	output logic                              q_valid,
	output logic [stsc_pkg::QCNT_W-1:0]       count
);

	stsc_pkg::token_t mem [stsc_pkg::QDEPTH];

	logic [stsc_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [stsc_pkg::QCNT_W-1:0] cnt_q;
	logic [1:0]                  n_push;

	assign n_push  = {1'b0, push.a_v} + {1'b0, push.b_v};
	assign head    = mem[rd_q];
	assign q_valid = (cnt_q != '0);
	assign count   = cnt_q;

	always_ff @(posedge clk) begin
		if (push.a_v && push.b_v) begin
			mem[wr_q]                                   <= push.a;
			mem[stsc_pkg::QPTR_W'(wr_q + 1'b1)]         <= push.b;
		end else if (push.a_v) begin
			mem[wr_q] <= push.a;
		end else if (push.b_v) begin
			mem[wr_q] <= push.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= stsc_pkg::QPTR_W'(wr_q + stsc_pkg::QPTR_W'(n_push));
			if (pop) begin
				rd_q <= stsc_pkg::QPTR_W'(rd_q + 1'b1);
			end
			cnt_q <= stsc_pkg::QCNT_W'(cnt_q + stsc_pkg::QCNT_W'(n_push)
				- stsc_pkg::QCNT_W'(pop));
		end
	end

endmodule
`default_nettype wire

>>> src/stsc_back.sv
// Back end: output register that takes tokens from the queue and holds them
// while the output channel stalls. Depends on stsc_pkg.
`default_nettype none
module stsc_back (
	input  wire  logic       clk,
	input  wire  logic       arst_n,
	input  wire  stsc_pkg::token_t head,
	input  wire  logic       q_valid,
	output logic             pop,
	input  wire  logic       out_stall,
	output logic             out_valid,
	output stsc_pkg::token_t tok
);

	logic             valid_q;
	stsc_pkg::token_t tok_q;

	assign pop       = q_valid && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign tok       = tok_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			tok_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

>>> tb/source_token_scanner_core_tb.sv
// Self-checking testbench for source_token_scanner_core: byte stream in, tokens out.
// Depends on stsc_pkg for the token layout and the kind and character codes.
`timescale 1ns / 100ps
module source_token_scanner_core_tb;

	localparam int ITEM_TARGET = 1450;
	localparam int LONG_RUN    = 60;
	localparam int STALL_LIMIT = 1000;

	class token_ledger;
		stsc_pkg::mode_t  mode;
		stsc_pkg::kw_t    kw;
		logic [15:0]      tok_start;
		logic [15:0]      tok_len;
		logic [15:0]      cur_pos;
		logic             prev_us;
		stsc_pkg::token_t tokens_due[$];
		int               errors;
		string            op_set = "(){}+-*/;,";
		string            word_begin = "begin";
		string            word_end = "end";

		function new();
			clear();
			errors = 0;
		endfunction

		function void clear();
			mode = stsc_pkg::MODE_IDLE;
			kw = stsc_pkg::KW_NONE;
			tok_start = '0;
			tok_len = '0;
			cur_pos = '0;
			prev_us = 1'b0;
		endfunction

		function logic digit_ch(logic [7:0] b);
			return b >= "0" && b <= "9";
		endfunction

		function logic letter_ch(logic [7:0] b);
			return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
		endfunction

		function logic [15:0] sat(logic [15:0] v);
			return (v == 16'hFFFF) ? v : v + 16'd1;
		endfunction

		function void push_token(logic [4:0] k, logic [15:0] s, logic [15:0] l, logic [7:0] u);
			stsc_pkg::token_t t;
			t.kind = k;
			t.start = s;
			t.length = l;
			t.ubyte = u;
			t.last = 1'b0;
			tokens_due.push_back(t);
		endfunction

		function void close_ident();
			logic [4:0] k;
			k = stsc_pkg::KIND_IDENT;
			if (prev_us)
				k = stsc_pkg::KIND_TRAIL_US;
			else if (kw == stsc_pkg::KW_BEGIN && tok_len == 16'd5)
				k = stsc_pkg::KIND_BEGIN;
			else if (kw == stsc_pkg::KW_END && tok_len == 16'd3)
				k = stsc_pkg::KIND_END_KW;
			push_token(k, tok_start, tok_len, 8'h00);
		endfunction

		function void grow_ident(logic [7:0] b);
			if (kw == stsc_pkg::KW_BEGIN && !(tok_len < 16'd5 && word_begin[tok_len] == b))
				kw = stsc_pkg::KW_NONE;
			else if (kw == stsc_pkg::KW_END && !(tok_len < 16'd3 && word_end[tok_len] == b))
				kw = stsc_pkg::KW_NONE;
			tok_len = sat(tok_len);
			prev_us = (b == stsc_pkg::CH_US);
		endfunction

		function void rescan(logic [7:0] b, logic [15:0] p);
			mode = stsc_pkg::MODE_IDLE;
			if (b == stsc_pkg::CH_SPACE || b == stsc_pkg::CH_TAB || b == stsc_pkg::CH_NL)
				return;
			if (b == stsc_pkg::CH_TILDE) begin
				mode = stsc_pkg::MODE_COMM;
				return;
			end
			if (digit_ch(b) || letter_ch(b) || b == stsc_pkg::CH_EQ) begin
				tok_start = p;
				tok_len = 16'd1;
				if (b == stsc_pkg::CH_EQ) begin
					mode = stsc_pkg::MODE_EQ;
				end else if (digit_ch(b)) begin
					mode = stsc_pkg::MODE_NUM;
				end else begin
					mode = stsc_pkg::MODE_ID;
					prev_us = 1'b0;
					if (b == "b")
						kw = stsc_pkg::KW_BEGIN;
					else if (b == "e")
						kw = stsc_pkg::KW_END;
					else
						kw = stsc_pkg::KW_NONE;
				end
				return;
			end
			for (int i = 0; i < 10; i++) begin
				if (op_set[i] == b) begin
					push_token(stsc_pkg::KIND_OP_BASE + 5'(i), p, 16'd1, 8'h00);
					return;
				end
			end
			push_token(stsc_pkg::KIND_UNKNOWN, p, 16'd1, b);
		endfunction

		function void take_byte(logic [7:0] b);
			int          n_before;
			logic [15:0] p;
			n_before = tokens_due.size();
			p = cur_pos;
			if (b == stsc_pkg::CH_END) begin
				case (mode)
					stsc_pkg::MODE_NUM:
						push_token(stsc_pkg::KIND_NUMBER, tok_start, tok_len, 8'h00);
					stsc_pkg::MODE_ID: close_ident();
					stsc_pkg::MODE_EQ:
						push_token(stsc_pkg::KIND_ASSIGN, tok_start, 16'd1, 8'h00);
					default: ;
				endcase
				push_token(stsc_pkg::KIND_END, p, 16'd0, 8'h00);
				clear();
			end else begin
				case (mode)
					stsc_pkg::MODE_NUM: begin
						if (digit_ch(b)) begin
							tok_len = sat(tok_len);
						end else begin
							push_token(stsc_pkg::KIND_NUMBER, tok_start, tok_len, 8'h00);
							rescan(b, p);
						end
					end
					stsc_pkg::MODE_ID: begin
						if (b == stsc_pkg::CH_US && prev_us) begin
							push_token(stsc_pkg::KIND_DOUBLE_US, tok_start, tok_len, 8'h00);
							rescan(b, p);
						end else if (letter_ch(b) || digit_ch(b) || b == stsc_pkg::CH_US) begin
							grow_ident(b);
						end else begin
							close_ident();
							rescan(b, p);
						end
					end
					stsc_pkg::MODE_EQ: begin
						if (b == stsc_pkg::CH_EQ) begin
							push_token(stsc_pkg::KIND_EQUAL, tok_start, 16'd2, 8'h00);
							mode = stsc_pkg::MODE_IDLE;
						end else begin
							push_token(stsc_pkg::KIND_ASSIGN, tok_start, 16'd1, 8'h00);
							rescan(b, p);
						end
					end
					stsc_pkg::MODE_COMM: begin
						if (b == stsc_pkg::CH_NL)
							mode = stsc_pkg::MODE_IDLE;
					end
					default: rescan(b, p);
				endcase
				cur_pos = sat(p);
			end
			if (tokens_due.size() > n_before)
				tokens_due[tokens_due.size() - 1].last = 1'b1;
		endfunction

		task report(string what);
			errors++;
			$display("%0t: token mismatch: %s", $realtime, what);
		endtask

		task match_token(stsc_pkg::token_t got);
			stsc_pkg::token_t want;
			if (tokens_due.size() == 0) begin
				report($sformatf("unexpected token kind %0d start %0d length %0d",
					got.kind, got.start, got.length));
				return;
			end
			want = tokens_due.pop_front();
			if (got.kind !== want.kind)
				report($sformatf("kind %0d, want %0d", got.kind, want.kind));
			if (got.start !== want.start)
				report($sformatf("start %0d, want %0d", got.start, want.start));
			if (got.length !== want.length)
				report($sformatf("length %0d, want %0d", got.length, want.length));
			if (got.ubyte !== want.ubyte)
				report($sformatf("unknown byte %0h, want %0h", got.ubyte, want.ubyte));
			if (got.last !== want.last)
				report($sformatf("last flag %0b, want %0b", got.last, want.last));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  source_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [4:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic [7:0]  unknown_byte;
	logic        last_of_run;

	token_ledger ledger = new();
	int          items = 0;
	int          gap_pct = 0;
	int          stall_pct = 0;
	int          idle_cycles = 0;
	logic        quiet = 1'b0;
	string       word_list[12] = '{"begin", "end", "beg", "en", "ends", "begins", "e", "b",
		"bEgin", "END", "end_", "be_gin"};

	source_token_scanner_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.source_byte(source_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.token_kind(token_kind),
		.token_start(token_start),
		.token_length(token_length),
		.unknown_byte(unknown_byte),
		.last_of_run(last_of_run)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		logic took_in;
		logic took_out;
		took_in = arst_n && in_valid && in_stall === 1'b0;
		took_out = arst_n && out_valid === 1'b1 && !out_stall;
		if (took_in)
			ledger.take_byte(source_byte);
		if (took_out)
			ledger.match_token(stsc_pkg::token_t'({token_kind, token_start, token_length,
				unknown_byte, last_of_run}));
		if (took_in || took_out) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("source_token_scanner_core_tb: done, errors");
				$finish;
			end
		end
	end

	function automatic int pick_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 10;
			default: return 40;
		endcase
	endfunction

	initial begin
		int n_cycles;
		n_cycles = 0;
		forever begin
			@(posedge clk);
			n_cycles++;
			if (n_cycles % 64 == 0)
				stall_pct = pick_pct();
			if (quiet || stall_pct == 0 || $urandom_range(0, 99) >= stall_pct) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		source_byte <= b;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		items++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	function automatic logic [7:0] any_letter();
		logic [7:0] c;
		c = 8'($urandom_range(0, 25));
		return $urandom_range(0, 1) ? 8'h41 + c : 8'h61 + c;
	endfunction

	function automatic logic [7:0] any_digit();
		return 8'h30 + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] any_blank();
		case ($urandom_range(0, 2))
			0: return stsc_pkg::CH_SPACE;
			1: return stsc_pkg::CH_TAB;
			default: return stsc_pkg::CH_NL;
		endcase
	endfunction

	task automatic send_number();
		int n;
		n = $urandom_range(1, 5);
		for (int i = 0; i < n; i++)
			send_byte(any_digit());
	endtask

	task automatic send_word();
		int n;
		int r;
		n = $urandom_range(0, 6);
		send_byte(any_letter());
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 15)
				send_byte(stsc_pkg::CH_US);
			else if (r < 35)
				send_byte(any_digit());
			else
				send_byte(any_letter());
		end
		if ($urandom_range(0, 7) == 0)
			send_byte(stsc_pkg::CH_US);
	endtask

	task automatic send_comment();
		logic [7:0] c;
		send_byte(stsc_pkg::CH_TILDE);
		repeat ($urandom_range(0, 8)) begin
			c = 8'($urandom_range(32, 126));
			send_byte(c == stsc_pkg::CH_END ? stsc_pkg::CH_US : c);
		end
		if ($urandom_range(0, 9) != 0)
			send_byte(stsc_pkg::CH_NL);
	endtask

	initial begin
		int pick;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("begin end=9==a__b_(;,");
		send_byte(8'hFF);
		send_byte(8'h00);
		send_text("~q\n $=$x_$7~c$");

		repeat (LONG_RUN) send_byte("7");
		send_byte(stsc_pkg::CH_END);
		repeat (LONG_RUN) send_byte(stsc_pkg::CH_SPACE);
		send_text("ab$");

		while (items < ITEM_TARGET) begin
			if (items >= ITEM_TARGET - 200)
				quiet = 1'b1;
			if ($urandom_range(0, 39) == 0)
				gap_pct = pick_pct();
			pick = $urandom_range(0, 99);
			if (pick < 18)
				send_number();
			else if (pick < 40)
				send_word();
			else if (pick < 50)
				send_text(word_list[$urandom_range(0, 11)]);
			else if (pick < 58)
				send_text($urandom_range(0, 2) == 0 ? "===" : ($urandom_range(0, 1) ? "==" : "="));
			else if (pick < 70)
				send_byte(ledger.op_set[$urandom_range(0, 9)]);
			else if (pick < 75)
				send_comment();
			else if (pick < 83)
				send_byte(8'($urandom_range(0, 255)));
			else if (pick < 88)
				send_text("$");
			else
				repeat ($urandom_range(1, 3)) send_byte(any_blank());
			if ($urandom_range(0, 1))
				send_byte(any_blank());
		end
		in_valid <= 1'b0;

		while (ledger.tokens_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (ledger.errors == 0)
			$display("source_token_scanner_core_tb: done, clean");
		else
			$display("source_token_scanner_core_tb: done, errors");
		$finish;
	end

endmodule
